FILE: hdl/ecpa_pkg.sv
// Package with the widths, payload types, register indexes and modular helpers of the EC block.
package ecpa_pkg;

  localparam int COORD_W    = 6;
  localparam int SCALAR_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [COORD_W:0]    coord_ext_t;
  typedef logic [SCALAR_W-1:0] scalar_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_PRIME = 2'd0,
    REG_CURVE_A     = 2'd1,
    REG_GROUP_ORDER = 2'd2
  } cfg_reg_e;

  localparam coord_t  FIELD_PRIME_RST = coord_t'(37);
  localparam coord_t  CURVE_A_RST     = coord_t'(2);
  localparam scalar_t GROUP_ORDER_RST = scalar_t'(43);
  localparam coord_t  MIN_PRIME       = coord_t'(3);

  typedef struct packed {
    logic    kind;
    scalar_t scalar;
    coord_t  a_x;
    coord_t  a_y;
    coord_t  b_x;
    coord_t  b_y;
  } ecpa_in_t;

  typedef struct packed {
    coord_t res_x;
    coord_t res_y;
    logic   at_infinity;
  } ecpa_out_t;

  // Request to the modular multiplier: u must be below p, v may be any value.
  typedef struct packed {
    logic   start;
    coord_t u;
    coord_t v;
    coord_t p;
  } mm_req_t;

  // Request to the inverse search: v must be below p.
  typedef struct packed {
    logic   start;
    coord_t v;
    coord_t p;
  } inv_req_t;

  typedef struct packed {
    logic   done;
    coord_t res;
  } unit_resp_t;

  // Sum of two residues below p, reduced once.
  function automatic coord_t add_mod(coord_t a, coord_t b, coord_t p);
    coord_ext_t s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[COORD_W-1:0];
  endfunction

  // Difference of two residues below p, wrapped into the field.
  function automatic coord_t sub_mod(coord_t a, coord_t b, coord_t p);
    coord_ext_t s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, p} - {1'b0, b};
    end
    return s[COORD_W-1:0];
  endfunction

endpackage

FILE: hdl/ecpa_mulmod.sv
// Bit-serial modular multiplier: one bit of the multiplier per cycle, MSB first.
module ecpa_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ecpa_pkg::mm_req_t req_i,
  output ecpa_pkg::unit_resp_t resp_o
);
  import ecpa_pkg::*;

  localparam int CNT_W = $clog2(COORD_W);

  logic             busy_q;
  logic             done_q;
  coord_t           r_q;
  coord_t           u_q;
  coord_t           v_q;
  coord_t           p_q;
  logic [CNT_W-1:0] cnt_q;
  coord_t           dbl;
  coord_t           nxt;

  // Double the partial result, then add u when the current bit is set.
  always_comb begin
    dbl = add_mod(r_q, r_q, p_q);
    nxt = v_q[COORD_W-1] ? add_mod(dbl, u_q, p_q) : dbl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        r_q    <= '0;
        u_q    <= req_i.u;
        v_q    <= req_i.v;
        p_q    <= req_i.p;
        cnt_q  <= CNT_W'(COORD_W - 1);
      end else if (busy_q) begin
        r_q <= nxt;
        v_q <= {v_q[COORD_W-2:0], 1'b0};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  assign resp_o.done = done_q;
  assign resp_o.res  = r_q;

  // A new operation never lands on one in flight.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("mulmod started while busy");

  // The result pulse follows the last step of a running operation.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("mulmod done without a running operation");

endmodule

FILE: hdl/ecpa_inv.sv
// Modular inverse by linear search: keeps v*i mod p with one add per candidate i.
module ecpa_inv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecpa_pkg::inv_req_t req_i,
  output ecpa_pkg::unit_resp_t resp_o
);
  import ecpa_pkg::*;

  logic   busy_q;
  logic   done_q;
  coord_t r_q;
  coord_t i_q;
  coord_t v_q;
  coord_t p_q;
  coord_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        r_q    <= req_i.v;
        v_q    <= req_i.v;
        p_q    <= req_i.p;
        i_q    <= coord_t'(1);
      end else if (busy_q) begin
        if (r_q == coord_t'(1)) begin
          // Found the inverse.
          res_q  <= i_q;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (i_q == p_q - coord_t'(1)) begin
          // No inverse exists: report zero.
          res_q  <= '0;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q <= i_q + coord_t'(1);
          r_q <= add_mod(r_q, v_q, p_q);
        end
      end
    end
  end

  assign resp_o.done = done_q;
  assign resp_o.res  = res_q;

endmodule

FILE: hdl/ec_point_add_scalar_mult.sv
// Top level: configuration registers, operation sequencer and result register of the EC block.
// A scalar multiply runs one point addition per remaining multiple of the reduced scalar.
// Each addition is bounded by the inverse search and up to four passes of the
// bit-serial multiplier. One item is in work at a time.
// Reset restores field_prime 37, curve_a 2, group_order 43 and leaves no result pending.
module ec_point_add_scalar_mult (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ecpa_pkg::ecpa_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ecpa_pkg::ecpa_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ecpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ecpa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ecpa_pkg::*;

  localparam int KBIT_W = $clog2(SCALAR_W);

  typedef enum logic [4:0] {
    S_IDLE, S_RED_CA, S_RED_AX, S_RED_AY, S_RED_BX, S_RED_BY, S_KRED, S_KSET,
    S_ADD_CHK, S_DBL_SQ, S_DBL_NUM, S_INV, S_MUL_S, S_SQ_S, S_RX, S_MUL_Y, S_RY, S_DONE
  } state_e;

  state_e  state_q;
  coord_t  field_prime_q;
  coord_t  curve_a_q;
  scalar_t group_order_q;
  coord_t  p_now;

  logic    mm_pend_q;
  logic    inv_pend_q;
  logic    kind_q;
  coord_t  p_q;
  coord_t  ca_q;
  coord_t  ax_q;
  coord_t  ay_q;
  logic    ainf_q;
  coord_t  bx_q;
  coord_t  by_q;
  logic    binf_q;
  coord_t  t_q;
  coord_t  d_q;
  coord_t  s_q;
  coord_t  rx_q;
  logic    dbl_q;
  scalar_t cnt_q;
  scalar_t ksh_q;
  scalar_t rem_q;
  logic [KBIT_W-1:0] kbit_q;
  logic      out_valid_q;
  ecpa_out_t out_q;

  mm_req_t    mm_req;
  inv_req_t   inv_req;
  unit_resp_t mm_resp;
  unit_resp_t inv_resp;

  logic       accept;
  logic [SCALAR_W:0] krem_t;
  coord_t     rx_new;
  coord_t     num_dbl;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_prime_q <= FIELD_PRIME_RST;
      curve_a_q     <= CURVE_A_RST;
      group_order_q <= GROUP_ORDER_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_FIELD_PRIME) begin
        field_prime_q <= cfg_data_i[COORD_W-1:0];
      end else if (cfg_idx_i == REG_CURVE_A) begin
        curve_a_q <= cfg_data_i[COORD_W-1:0];
      end else if (cfg_idx_i == REG_GROUP_ORDER) begin
        group_order_q <= cfg_data_i[SCALAR_W-1:0];
      end
    end
  end

  // Effective modulus: anything below three counts as three.
  assign p_now = (field_prime_q < MIN_PRIME) ? MIN_PRIME : field_prime_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Operand selection for the shared multiplier and the inverse search.
  always_comb begin
    mm_req.start = 1'b0;
    mm_req.u     = coord_t'(1);
    mm_req.v     = ax_q;
    mm_req.p     = p_q;
    unique case (state_q)
      S_RED_CA: begin
        mm_req.start = !mm_pend_q;
        mm_req.v     = ca_q;
      end
      S_RED_AX: begin
        mm_req.start = !mm_pend_q;
        mm_req.v     = ax_q;
      end
      S_RED_AY: begin
        mm_req.start = !mm_pend_q;
        mm_req.v     = ay_q;
      end
      S_RED_BX: begin
        mm_req.start = !mm_pend_q;
        mm_req.v     = bx_q;
      end
      S_RED_BY: begin
        mm_req.start = !mm_pend_q;
        mm_req.v     = by_q;
      end
      S_DBL_SQ: begin
        mm_req.start = !mm_pend_q;
        mm_req.u     = ax_q;
        mm_req.v     = ax_q;
      end
      S_MUL_S: begin
        mm_req.start = !mm_pend_q;
        mm_req.u     = t_q;
        mm_req.v     = d_q;
      end
      S_SQ_S: begin
        mm_req.start = !mm_pend_q;
        mm_req.u     = s_q;
        mm_req.v     = s_q;
      end
      S_MUL_Y: begin
        mm_req.start = !mm_pend_q;
        mm_req.u     = s_q;
        mm_req.v     = t_q;
      end
      default: begin
        mm_req.start = 1'b0;
      end
    endcase
    inv_req.start = !inv_pend_q && (state_q == S_INV);
    inv_req.v     = d_q;
    inv_req.p     = p_q;
  end

  // Restoring remainder step for the scalar, and the slope and x formulas.
  always_comb begin
    krem_t = {rem_q, ksh_q[SCALAR_W-1]};
    if (krem_t >= {1'b0, group_order_q}) begin
      krem_t = krem_t - {1'b0, group_order_q};
    end
    num_dbl = add_mod(add_mod(add_mod(t_q, t_q, p_q), t_q, p_q), ca_q, p_q);
    rx_new  = dbl_q ? sub_mod(t_q, add_mod(ax_q, ax_q, p_q), p_q)
                    : sub_mod(sub_mod(t_q, ax_q, p_q), bx_q, p_q);
  end

  ecpa_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .resp_o (mm_resp)
  );

  ecpa_inv u_inv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (inv_req),
    .resp_o (inv_resp)
  );

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mm_pend_q   <= 1'b0;
      inv_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mm_req.start) begin
        mm_pend_q <= 1'b1;
      end else if (mm_resp.done) begin
        mm_pend_q <= 1'b0;
      end
      if (inv_req.start) begin
        inv_pend_q <= 1'b1;
      end else if (inv_resp.done) begin
        inv_pend_q <= 1'b0;
      end
      // The result beat leaves here unless a new one is loaded in the same cycle.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q <= in_data_i.kind;
            p_q    <= p_now;
            ca_q   <= curve_a_q;
            ax_q   <= in_data_i.a_x;
            ay_q   <= in_data_i.a_y;
            bx_q   <= in_data_i.b_x;
            by_q   <= in_data_i.b_y;
            ainf_q <= (in_data_i.a_x == p_now);
            binf_q <= (in_data_i.b_x == p_now);
            ksh_q  <= in_data_i.scalar;
            rem_q  <= '0;
            kbit_q <= KBIT_W'(SCALAR_W - 1);
            state_q <= S_RED_CA;
          end
        end
        S_RED_CA: begin
          if (mm_resp.done) begin
            ca_q    <= mm_resp.res;
            state_q <= S_RED_AX;
          end
        end
        S_RED_AX: begin
          if (mm_resp.done) begin
            ax_q    <= mm_resp.res;
            state_q <= S_RED_AY;
          end
        end
        S_RED_AY: begin
          if (mm_resp.done) begin
            ay_q    <= mm_resp.res;
            state_q <= kind_q ? S_KRED : S_RED_BX;
          end
        end
        S_RED_BX: begin
          if (mm_resp.done) begin
            bx_q    <= mm_resp.res;
            state_q <= S_RED_BY;
          end
        end
        S_RED_BY: begin
          if (mm_resp.done) begin
            by_q    <= mm_resp.res;
            cnt_q   <= scalar_t'(2);
            state_q <= S_ADD_CHK;
          end
        end
        S_KRED: begin
          if (group_order_q == '0) begin
            // No reduction when the group order is zero.
            rem_q   <= ksh_q;
            state_q <= S_KSET;
          end else begin
            rem_q <= krem_t[SCALAR_W-1:0];
            ksh_q <= {ksh_q[SCALAR_W-2:0], 1'b0};
            if (kbit_q == '0) begin
              state_q <= S_KSET;
            end else begin
              kbit_q <= kbit_q - KBIT_W'(1);
            end
          end
        end
        S_KSET: begin
          // A reduced scalar of zero acts as one; the sum starts at A.
          cnt_q   <= (rem_q == '0) ? scalar_t'(1) : rem_q;
          bx_q    <= ax_q;
          by_q    <= ay_q;
          binf_q  <= ainf_q;
          state_q <= S_ADD_CHK;
        end
        S_ADD_CHK: begin
          if (cnt_q == scalar_t'(1)) begin
            state_q <= S_DONE;
          end else if (ainf_q) begin
            cnt_q <= cnt_q - scalar_t'(1);
          end else if (binf_q) begin
            bx_q   <= ax_q;
            by_q   <= ay_q;
            binf_q <= 1'b0;
            cnt_q  <= cnt_q - scalar_t'(1);
          end else if (ax_q == bx_q) begin
            if (ay_q != by_q || ay_q == '0) begin
              // Opposite points, or a doubling with y zero.
              binf_q <= 1'b1;
              cnt_q  <= cnt_q - scalar_t'(1);
            end else begin
              state_q <= S_DBL_SQ;
            end
          end else begin
            t_q     <= sub_mod(ay_q, by_q, p_q);
            d_q     <= sub_mod(ax_q, bx_q, p_q);
            dbl_q   <= 1'b0;
            state_q <= S_INV;
          end
        end
        S_DBL_SQ: begin
          if (mm_resp.done) begin
            t_q     <= mm_resp.res;
            state_q <= S_DBL_NUM;
          end
        end
        S_DBL_NUM: begin
          t_q     <= num_dbl;
          d_q     <= add_mod(ay_q, ay_q, p_q);
          dbl_q   <= 1'b1;
          state_q <= S_INV;
        end
        S_INV: begin
          if (inv_resp.done) begin
            d_q     <= inv_resp.res;
            state_q <= S_MUL_S;
          end
        end
        S_MUL_S: begin
          if (mm_resp.done) begin
            s_q     <= mm_resp.res;
            state_q <= S_SQ_S;
          end
        end
        S_SQ_S: begin
          if (mm_resp.done) begin
            t_q     <= mm_resp.res;
            state_q <= S_RX;
          end
        end
        S_RX: begin
          rx_q    <= rx_new;
          t_q     <= sub_mod(ax_q, rx_new, p_q);
          state_q <= S_MUL_Y;
        end
        S_MUL_Y: begin
          if (mm_resp.done) begin
            t_q     <= mm_resp.res;
            state_q <= S_RY;
          end
        end
        S_RY: begin
          bx_q    <= rx_q;
          by_q    <= sub_mod(t_q, ay_q, p_q);
          binf_q  <= 1'b0;
          cnt_q   <= cnt_q - scalar_t'(1);
          state_q <= S_ADD_CHK;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.res_x       <= binf_q ? p_q : bx_q;
            out_q.res_y       <= binf_q ? p_q : by_q;
            out_q.at_infinity <= binf_q;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A multiplier result only arrives for a request the sequencer is waiting on.
  a_mm_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_resp.done |-> mm_pend_q)
    else $error("unexpected multiplier result");

  // Same for the inverse search.
  a_inv_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inv_resp.done |-> inv_pend_q)
    else $error("unexpected inverse result");

  // A finite result lies inside the field.
  a_res_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.at_infinity) |->
      (out_data_o.res_x < p_now) && (out_data_o.res_y < p_now))
    else $error("finite result outside the field");

endmodule
